// ===== hw/rtl/scs_pkg.sv =====
// shared constants and types for the stable counting sort block
// no dependencies; imported by every module of the block
package scs_pkg;

    // sizing of the block
    localparam int MAX_KEYS  = 64;
    localparam int KEY_SLOTS = 256;
    localparam int KEY_W     = 16;

    // configuration registers
    localparam int CFG_W     = 16;
    localparam int SPAN_W    = 9;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_MINIMUM = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_SPAN    = 1'd1;
    localparam logic [SPAN_W-1:0]    KEY_SPAN_RESET  = 9'd256;

    // derived widths
    localparam int SLOT_W = $clog2(KEY_SLOTS);
    localparam int IDX_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int SCAN_W = $clog2(KEY_SLOTS + 1);
    localparam int OFF_W  = ((KEY_W > CFG_W) ? KEY_W : CFG_W) + 1;
    localparam int SPAN_CMP_W = (SPAN_W > SCAN_W) ? SPAN_W : SCAN_W;

    // drop counter
    localparam int DROP_W = 7;
    localparam logic [DROP_W-1:0] DROP_MAX = 7'd127;

    // stream widths
    localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_W + DROP_W + 7) / 8) * 8;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // one classified key on its way to the back end
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic              in_span;
        logic              last;
    } scs_entry_t;

endpackage

// ===== hw/rtl/scs_front.sv =====
// front end: configuration registers and key classification
// depends on scs_pkg; feeds scs_queue
module scs_front import scs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 q_push,
    output scs_entry_t           q_entry,
    input  logic                 q_full
);

    logic [CFG_W-1:0]      key_minimum_reg;
    logic [SPAN_W-1:0]     key_span_reg;
    logic [KEY_W-1:0]      key;
    logic [OFF_W-1:0]      key_ext;
    logic [OFF_W-1:0]      min_ext;
    logic [OFF_W-1:0]      offset;
    logic [SPAN_CMP_W-1:0] span_ext;
    logic [SPAN_CMP_W-1:0] span_lim;
    logic [SPAN_CMP_W-1:0] span_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_minimum_reg <= '0;
            key_span_reg    <= KEY_SPAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY_MINIMUM: key_minimum_reg <= cfg_wdata;
                REG_KEY_SPAN:    key_span_reg    <= cfg_wdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign key      = s_tdata[KEY_W-1:0];
    assign key_ext  = {{(OFF_W-KEY_W){key[KEY_W-1]}}, key};
    assign min_ext  = {{(OFF_W-CFG_W){key_minimum_reg[CFG_W-1]}}, key_minimum_reg};
    assign offset   = key_ext - min_ext;

    // span larger than the histogram is clamped
    assign span_ext = SPAN_CMP_W'(key_span_reg);
    assign span_lim = SPAN_CMP_W'(KEY_SLOTS);
    assign span_eff = (span_ext > span_lim) ? span_lim : span_ext;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.key     = key;
        q_entry.slot    = offset[SLOT_W-1:0];
        q_entry.in_span = !offset[OFF_W-1] && (offset < OFF_W'(span_eff));
        q_entry.last    = s_tlast;
    end

endmodule

// ===== hw/rtl/scs_queue.sv =====
// short fifo of classified keys between front and back end
// depends on scs_pkg
module scs_queue import scs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  scs_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output scs_entry_t pop_entry,
    output logic       not_empty
);

    scs_entry_t        q_mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_entry = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/scs_back.sv =====
// back end: key store, histogram, prefix scan, placement and result output
// depends on scs_pkg; drains scs_queue
module scs_back import scs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  scs_entry_t           q_entry,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_DRAIN  = 10'b0000000010,
        ST_PREFIX = 10'b0000000100,
        ST_PL_RD  = 10'b0000001000,
        ST_PL_HR  = 10'b0000010000,
        ST_PL_WR  = 10'b0000100000,
        ST_EM_RD  = 10'b0001000000,
        ST_EM_LD  = 10'b0010000000,
        ST_EMPTY  = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [DROP_W-1:0] dropped_reg, dropped_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  kept_last;

    // key store: slot in the upper bits, key in the lower
    logic [SLOT_W+KEY_W-1:0] store_mem [MAX_KEYS];
    logic [SLOT_W+KEY_W-1:0] st_rd_reg;
    logic                    st_we;
    logic [SLOT_W+KEY_W-1:0] st_wd;
    logic [SLOT_W-1:0]       st_slot;
    logic [KEY_W-1:0]        st_key;

    // histogram, later placement positions
    logic [CNT_W-1:0]     hist_mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] hist_vld_reg;
    logic [CNT_W-1:0]     h_rd_reg;
    logic                 hv_rd_reg;
    logic                 h_we;
    logic [SLOT_W-1:0]    h_wa;
    logic [CNT_W-1:0]     h_wd;
    logic [SLOT_W-1:0]    h_ra;
    logic [CNT_W-1:0]     h_cur;

    // sorted output buffer
    logic [KEY_W-1:0] sorted_mem [MAX_KEYS];
    logic [KEY_W-1:0] sb_rd_reg;
    logic             sb_we;
    logic [CNT_W-1:0] pos_dec;

    // histogram increment pipeline with one-entry bypass
    logic              kept_ok;
    logic              b_vld_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic              fw_vld_reg;
    logic [SLOT_W-1:0] fw_slot_reg;
    logic [CNT_W-1:0]  fw_val_reg;
    logic [CNT_W-1:0]  b_new;

    // prefix scan
    logic [SCAN_W-1:0] pfx_idx_reg, pfx_idx_next;
    logic              p_vld_reg, p_vld_next;
    logic [SLOT_W-1:0] p_addr_reg;
    logic [CNT_W-1:0]  run_reg, run_next;

    // result register
    logic              out_vld_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_end_reg;
    logic              out_empty_reg;
    logic [DROP_W-1:0] out_drop_reg;
    logic              out_free;
    logic              out_load;
    logic [KEY_W-1:0]  out_key_next;
    logic              out_end_next;
    logic              out_empty_next;

    assign q_pop   = (state_reg == ST_LOAD) && q_valid;
    assign kept_ok = q_pop && q_entry.in_span && (kept_reg < CNT_W'(MAX_KEYS));
    assign st_we   = kept_ok;
    assign st_wd   = {q_entry.slot, q_entry.key};
    assign st_slot = st_rd_reg[SLOT_W+KEY_W-1:KEY_W];
    assign st_key  = st_rd_reg[KEY_W-1:0];

    assign kept_last = IDX_W'(kept_reg - 1'b1);
    assign out_free  = !out_vld_reg || m_tready;
    assign h_cur     = hv_rd_reg ? h_rd_reg : '0;
    assign b_new     = ((fw_vld_reg && (fw_slot_reg == b_slot_reg)) ? fw_val_reg : h_cur)
                       + 1'b1;
    assign pos_dec   = h_rd_reg - 1'b1;
    assign sb_we     = (state_reg == ST_PL_WR) && (h_rd_reg != '0);

    // histogram port selection
    always_comb begin
        unique case (state_reg)
            ST_LOAD:   h_ra = q_entry.slot;
            ST_PREFIX: h_ra = pfx_idx_reg[SLOT_W-1:0];
            ST_PL_HR:  h_ra = st_slot;
            default:   h_ra = st_slot;
        endcase
        h_we = 1'b0;
        h_wa = b_slot_reg;
        h_wd = b_new;
        if (b_vld_reg) begin
            h_we = 1'b1;
        end else if (p_vld_reg) begin
            h_we = 1'b1;
            h_wa = p_addr_reg;
            h_wd = run_next;
        end else if (sb_we) begin
            h_we = 1'b1;
            h_wa = st_slot;
            h_wd = pos_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[kept_reg[IDX_W-1:0]] <= st_wd;
        end
        st_rd_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (h_we) begin
            hist_mem[h_wa] <= h_wd;
        end
        h_rd_reg <= hist_mem[h_ra];
    end

    always_ff @(posedge aclk) begin
        if (sb_we) begin
            sorted_mem[pos_dec[IDX_W-1:0]] <= st_key;
        end
        sb_rd_reg <= sorted_mem[idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        pfx_idx_next   = pfx_idx_reg;
        p_vld_next     = 1'b0;
        run_next       = p_vld_reg ? (run_reg + h_cur) : run_reg;
        out_load       = 1'b0;
        out_key_next   = sb_rd_reg;
        out_end_next   = (idx_reg == kept_last);
        out_empty_next = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (kept_ok) begin
                    kept_next = kept_reg + 1'b1;
                end else if (q_pop && (dropped_reg != DROP_MAX)) begin
                    dropped_next = dropped_reg + 1'b1;
                end
                if (q_pop && q_entry.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                pfx_idx_next = '0;
                run_next     = '0;
                state_next   = (kept_reg == '0) ? ST_EMPTY : ST_PREFIX;
            end
            ST_PREFIX: begin
                if (pfx_idx_reg == SCAN_W'(KEY_SLOTS)) begin
                    idx_next   = kept_last;
                    state_next = ST_PL_RD;
                end else begin
                    p_vld_next   = 1'b1;
                    pfx_idx_next = pfx_idx_reg + 1'b1;
                end
            end
            ST_PL_RD: state_next = ST_PL_HR;
            ST_PL_HR: state_next = ST_PL_WR;
            ST_PL_WR: begin
                if (idx_reg == '0) begin
                    state_next = ST_EM_RD;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_PL_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_LD;
            ST_EM_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_end_next) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            ST_EMPTY: begin
                out_key_next   = '0;
                out_end_next   = 1'b1;
                out_empty_next = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                kept_next    = '0;
                dropped_next = '0;
                idx_next     = '0;
                state_next   = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            kept_reg     <= '0;
            dropped_reg  <= '0;
            idx_reg      <= '0;
            pfx_idx_reg  <= '0;
            p_vld_reg    <= 1'b0;
            run_reg      <= '0;
            b_vld_reg    <= 1'b0;
            fw_vld_reg   <= 1'b0;
            hist_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kept_reg    <= kept_next;
            dropped_reg <= dropped_next;
            idx_reg     <= idx_next;
            pfx_idx_reg <= pfx_idx_next;
            p_vld_reg   <= p_vld_next;
            run_reg     <= run_next;
            b_vld_reg   <= kept_ok;
            fw_vld_reg  <= b_vld_reg;
            if (state_reg == ST_FINISH) begin
                hist_vld_reg <= '0;
            end else if (h_we) begin
                hist_vld_reg[h_wa] <= 1'b1;
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        b_slot_reg  <= q_entry.slot;
        fw_slot_reg <= b_slot_reg;
        fw_val_reg  <= b_new;
        p_addr_reg  <= pfx_idx_reg[SLOT_W-1:0];
        hv_rd_reg   <= hist_vld_reg[h_ra];
        if (out_load) begin
            out_key_reg   <= out_key_next;
            out_end_reg   <= out_end_next;
            out_empty_reg <= out_empty_next;
            out_drop_reg  <= dropped_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'({out_drop_reg, out_key_reg});
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_empty_reg;

    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= CNT_W'(MAX_KEYS))
        else $error("kept count above buffer capacity");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> kept_reg == '0 && dropped_reg == '0 && hist_vld_reg == '0)
        else $error("run state not cleared after output");

    a_place_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PL_WR |-> h_rd_reg != '0)
        else $error("placement position exhausted");

    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_empty_reg |-> out_end_reg)
        else $error("empty result without run end");

endmodule

// ===== hw/rtl/stable_counting_sort.sv =====
// top level of the stable counting sort block
// depends on scs_pkg, scs_front, scs_queue and scs_back
//
// usage
//   s_ channel: one signed key per item, s_tlast marks the final key of a set
//   m_ channel: the kept keys in stable ascending order, m_tlast on the final one;
//     m_tuser flags an empty run (no key kept), which gives a single item with key 0
//   m_tdata also carries the saturating count of keys dropped in this run
//   keys outside [key_minimum, key_minimum + span) or beyond 64 kept keys are dropped
//   configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//     (0 = key_minimum, 1 = key_span); the user must write only while the block is idle (no guard in it)
// timing
//   keys are taken one per cycle while the four-entry queue has room
//   after the accept of the last key the back end runs the histogram prefix scan
//     (one slot per cycle), then a placement step per kept key (store read,
//     histogram read, position write) and a read-out step per kept key (buffer
//     read, result load); an empty run goes straight to its single empty item
//   during sorting the queue fills and s_tready drops until the run is sent
// reset: config returns to key_minimum = 0, key_span = 256; histogram, counts
//   and queue are empty; no result pending
// receiver stall: the result register holds its item and the back end waits
module stable_counting_sort import scs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // key input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] key
    input  logic                 s_tlast,
    // sorted output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] sorted_key, [22:16] dropped_total
    output logic                 m_tlast,
    output logic                 m_tuser    // [0] empty_run
);

    // classified items between front and back end
    scs_entry_t push_entry;
    scs_entry_t pop_entry;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;

    // front: config registers, range check and slot index
    scs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .q_full    (q_full)
    );

    // decoupling queue
    scs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty)
    );

    // back: store, histogram, sort and result output
    scs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== verif/scs_sort_checker.sv =====
// scoreboard for the stable counting sort block: watches the config port and both streams
// depends on scs_pkg; keeps its own sorter and compares every sorted item in order
module scs_sort_checker import scs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] key
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [15:0] sorted_key, [22:16] dropped_total
    input  logic                 m_tlast,
    input  logic                 m_tuser,   // [0] empty_run
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              run_end;
        logic              empty;
        logic [DROP_W-1:0] dropped;
    } sorted_item_t;

    sorted_item_t            sorted_due[$];
    logic signed [KEY_W-1:0] held_key  [MAX_KEYS];
    logic [SLOT_W-1:0]       held_slot [MAX_KEYS];
    int unsigned             slot_count[KEY_SLOTS];
    int unsigned             kept_keys;
    int unsigned             drop_tally;
    logic signed [CFG_W-1:0] lo_key;
    logic [SPAN_W-1:0]       span_reg;

    // bin one key; on the final key build the sorted run
    function automatic void count_key(input logic signed [KEY_W-1:0] k, input logic lst);
        int           span_eff;
        int           offs;
        int unsigned  run_sum;
        int unsigned  fill[KEY_SLOTS];
        logic [KEY_W-1:0] ordered[MAX_KEYS];
        sorted_item_t item;
        span_eff = (span_reg > KEY_SLOTS) ? KEY_SLOTS : int'(span_reg);
        offs     = int'(k) - int'(lo_key);
        if (offs < 0 || offs >= span_eff || kept_keys >= MAX_KEYS) begin
            if (drop_tally < DROP_MAX) drop_tally++;
        end else begin
            held_key[kept_keys]  = k;
            held_slot[kept_keys] = offs[SLOT_W-1:0];
            slot_count[offs]++;
            kept_keys++;
        end
        if (!lst) return;
        if (kept_keys == 0) begin
            item = '{key: '0, run_end: 1'b1, empty: 1'b1, dropped: drop_tally[DROP_W-1:0]};
            sorted_due.push_back(item);
        end else begin
            run_sum = 0;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                run_sum += slot_count[s];
                fill[s] = run_sum;
            end
            // walk from the back so equal slots keep arrival order
            for (int j = int'(kept_keys) - 1; j >= 0; j--) begin
                fill[held_slot[j]]--;
                ordered[fill[held_slot[j]]] = held_key[j];
            end
            for (int j = 0; j < int'(kept_keys); j++) begin
                item = '{key: ordered[j], run_end: (j == int'(kept_keys) - 1), empty: 1'b0,
                         dropped: drop_tally[DROP_W-1:0]};
                sorted_due.push_back(item);
            end
        end
        for (int s = 0; s < KEY_SLOTS; s++) slot_count[s] = 0;
        kept_keys  = 0;
        drop_tally = 0;
    endfunction

    always @(posedge aclk) begin
        sorted_item_t want;
        if (!aresetn) begin
            sorted_due.delete();
            for (int s = 0; s < KEY_SLOTS; s++) slot_count[s] = 0;
            kept_keys  = 0;
            drop_tally = 0;
            lo_key     = '0;
            span_reg   = KEY_SPAN_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_KEY_MINIMUM) lo_key = cfg_wdata;
                else if (cfg_index == REG_KEY_SPAN) span_reg = cfg_wdata[SPAN_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (sorted_due.size() == 0) begin
                    $display("%0t: sorted item with none expected: key %h last %b empty %b",
                             $time, m_tdata[KEY_W-1:0], m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    want = sorted_due.pop_front();
                    if (m_tdata[KEY_W-1:0] !== want.key) begin
                        $display("%0t: sorted_key expected %h actual %h",
                                 $time, want.key, m_tdata[KEY_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.run_end) begin
                        $display("%0t: run_end expected %b actual %b",
                                 $time, want.run_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== want.empty) begin
                        $display("%0t: empty_run expected %b actual %b",
                                 $time, want.empty, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[KEY_W +: DROP_W] !== want.dropped) begin
                        $display("%0t: dropped_total expected %0d actual %0d",
                                 $time, want.dropped, m_tdata[KEY_W +: DROP_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) count_key(s_tdata[KEY_W-1:0], s_tlast);
        end
        pending <= sorted_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// top of the stable counting sort testbench: clock, reset, key stimulus and verdict
// depends on scs_pkg, stable_counting_sort and scs_sort_checker
module tb;
    import scs_pkg::*;

    // cycles the block may still need after the final sorted item of a run
    localparam int SETTLE_CYCLES = KEY_SLOTS + 5 * MAX_KEYS + 16;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_KEY_MINIMUM;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [15:0] key
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [15:0] sorted_key, [22:16] dropped_total
    logic                 m_tlast;
    logic                 m_tuser;          // [0] empty_run

    int fail_count;
    int pending;

    // quiet = no idling on either side
    bit quiet = 1'b0;

    // window currently programmed, mirrored here to aim keys into it
    logic signed [CFG_W-1:0] win_lo   = '0;
    logic [SPAN_W-1:0]       win_span = KEY_SPAN_RESET;

    int rand_items = 0;
    int run_len;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    stable_counting_sort DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    scs_sort_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: stalls at random about 29 percent of the time unless quiet
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 29);
    end

    // offer one key; valid stays up after the accept so back-to-back items
    // never see a low and a high in the same step
    task automatic send_item(input logic [KEY_W-1:0] k, input logic lst);
        while (!quiet && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(k);
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every sorted item is out, then lets the back end drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers on back-to-back cycles; only call after settle
    task automatic set_window(input logic signed [CFG_W-1:0] lo, input logic [SPAN_W-1:0] sp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_KEY_MINIMUM;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_KEY_SPAN;
        cfg_wdata <= CFG_W'(sp);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_lo   = lo;
        win_span = sp;
    endtask

    // mostly keys inside the window, some anywhere, some just outside its edges
    function automatic logic [KEY_W-1:0] pick_key();
        int eff;
        int roll;
        eff  = (win_span > KEY_SLOTS) ? KEY_SLOTS : int'(win_span);
        roll = $urandom_range(99);
        if (eff == 0 || roll < 12) return KEY_W'($urandom);
        if (roll < 16) return KEY_W'(int'(win_lo) - 1);
        if (roll < 20) return KEY_W'(int'(win_lo) + eff);
        return KEY_W'(int'(win_lo) + int'($urandom_range(eff - 1)));
    endfunction

    task automatic random_run(input int len);
        for (int j = 0; j < len; j++) send_item(pick_key(), j == len - 1);
    endtask

    // random window: narrow spans for many equal keys, plus zero and oversize spans
    task automatic random_window();
        int                roll;
        logic [SPAN_W-1:0] sp;
        roll = $urandom_range(99);
        if (roll < 6)       sp = '0;
        else if (roll < 14) sp = SPAN_W'($urandom_range(KEY_SLOTS + 1, (1 << SPAN_W) - 1));
        else if (roll < 40) sp = SPAN_W'($urandom_range(1, 8));
        else                sp = SPAN_W'($urandom_range(1, KEY_SLOTS));
        set_window(CFG_W'($urandom), sp);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window 0..255: edges, drops on both sides and the key extremes
        send_item(16'sd5, 1'b0);
        send_item(16'sd255, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sd256, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd5, 1'b0);
        send_item(16'sd3, 1'b0);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd32767, 1'b1);
        // empty run after a single dropped key
        send_item(16'sd1000, 1'b1);
        // run of one kept key
        send_item(16'sd7, 1'b1);
        settle();

        // lowest minimum, one-slot span
        set_window(-16'sd32768, 9'd1);
        send_item(-16'sd32768, 1'b0);
        send_item(-16'sd32767, 1'b0);
        send_item(-16'sd32768, 1'b1);
        settle();

        // highest minimum, span above the slot count is clipped
        set_window(16'sd32767, 9'd300);
        send_item(16'sd32767, 1'b0);
        send_item(16'sd32766, 1'b0);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd32767, 1'b1);
        settle();

        // zero span drops everything
        set_window(-16'sd100, 9'd0);
        send_item(16'sd1, 1'b0);
        send_item(-16'sd100, 1'b1);
        settle();

        // widest span field value
        set_window(-16'sd100, 9'd511);
        send_item(-16'sd100, 1'b0);
        send_item(16'sd155, 1'b0);
        send_item(16'sd156, 1'b0);
        send_item(16'sd0, 1'b1);
        settle();

        // random runs, short ones mostly, window changes between some of them
        set_window(-16'sd20, 9'd40);
        while (rand_items < 16) begin
            if ($urandom_range(3) == 0) begin
                settle();
                random_window();
            end
            run_len = $urandom_range(1, 10);
            random_run(run_len);
            rand_items += run_len;
        end
        settle();

        // buffer overflow with no idling on either side: more in-window keys than
        // the store holds
        quiet = 1'b1;
        set_window(-16'sd50, 9'd200);
        for (int j = 0; j < MAX_KEYS + 6; j++) begin
            send_item(KEY_W'(-50 + int'($urandom_range(199))), j == MAX_KEYS + 5);
        end
        settle();
        quiet = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
